// ===== sv/gtlw_pkg.sv =====
package gtlw_pkg;

    // Character codes that steer the line breaking
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_TAB     = 8'd9;

    // Character indices wrap at this length (16-bit index)
    localparam int MAX_TEXT_LEN = 65536;
    localparam int IDX_W        = $clog2(MAX_TEXT_LEN);

    localparam logic [15:0] WIDTH_MAX = 16'hFFFF;

    // Configuration register indices
    localparam logic [1:0] REG_WRAP_WIDTH = 2'd0;
    localparam logic [1:0] REG_WRAP_MODE  = 2'd1;

    // Wrap modes
    localparam logic [1:0] MODE_NEWLINE = 2'd0;
    localparam logic [1:0] MODE_LINE    = 2'd1;
    localparam logic [1:0] MODE_WORD    = 2'd2;

    // Output queue depth
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    // One reported line
    typedef struct packed {
        logic             last_of_run;
        logic             text_done;
        logic [15:0]      final_width;
        logic [15:0]      seg_length;
        logic [IDX_W-1:0] seg_start;
    } seg_t;

    // Lines produced by one character, pushed into the output queue
    typedef struct packed {
        logic [1:0] count;
        seg_t       first;
        seg_t       second;
    } push_t;

endpackage

// ===== sv/gtlw_core.sv =====
module gtlw_core import gtlw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        take,
    input  logic [7:0]  char_code,
    input  logic [7:0]  glyph_advance,
    input  logic        last_char,
    input  logic [15:0] wrap_width,
    input  logic [1:0]  wrap_mode,
    output push_t       push
);

    logic [IDX_W-1:0] char_index_reg, char_index_next;
    logic [IDX_W-1:0] line_begin_reg, line_begin_next;
    logic [IDX_W-1:0] space_index_reg, space_index_next;
    logic [15:0]      line_offset_reg, line_offset_next;
    logic [15:0]      word_width_reg, word_width_next;

    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] lb;
    logic [IDX_W-1:0] sp;
    logic [15:0]      off;
    logic [15:0]      ww;
    logic [16:0]      off_sum;
    logic [16:0]      ww_sum;
    logic             over;
    logic             is_blank;
    logic             brk;
    logic             flush;
    logic [IDX_W-1:0] brk_start;
    logic [15:0]      brk_len;
    seg_t             brk_seg;
    seg_t             flush_seg;

    // Next-state and line extraction for one character
    always_comb begin
        idx_inc  = char_index_reg + 1'b1;
        lb       = line_begin_reg;
        sp       = space_index_reg;
        off      = line_offset_reg;
        ww       = word_width_reg;
        ww_sum   = '0;
        off_sum  = '0;
        brk      = 1'b0;
        brk_start = line_begin_reg;
        brk_len  = 16'(char_index_reg - line_begin_reg);
        is_blank = (char_code == CH_SPACE) || (char_code == CH_TAB);
        over     = ({1'b0, line_offset_reg} + {9'd0, glyph_advance}) > {1'b0, wrap_width};

        if (char_code == CH_NEWLINE) begin
            brk = 1'b1;
            lb  = idx_inc;
            off = '0;
        end else begin
            if (wrap_mode == MODE_LINE) begin
                if (over) begin
                    brk = 1'b1;
                    lb  = char_index_reg;
                    off = '0;
                end
            end else if (wrap_mode == MODE_WORD) begin
                if (is_blank) begin
                    sp = char_index_reg;
                    ww = '0;
                end
                if (over) begin
                    brk = 1'b1;
                    if (sp > line_begin_reg) begin
                        brk_len = 16'(sp - line_begin_reg);
                        lb      = sp + 1'b1;
                        off     = ww;
                        ww      = '0;
                    end else begin
                        lb  = char_index_reg;
                        off = '0;
                    end
                end
                ww_sum = {1'b0, ww} + {9'd0, glyph_advance};
                ww     = ww_sum[16] ? WIDTH_MAX : ww_sum[15:0];
            end
            off_sum = {1'b0, off} + {9'd0, glyph_advance};
            off     = off_sum[16] ? WIDTH_MAX : off_sum[15:0];
        end

        flush = last_char && (off != '0);

        brk_seg.seg_start   = brk_start;
        brk_seg.seg_length  = brk_len;
        brk_seg.final_width = (last_char && !flush) ? off : '0;
        brk_seg.text_done   = last_char && !flush;
        brk_seg.last_of_run = !flush;

        flush_seg.seg_start   = lb;
        flush_seg.seg_length  = 16'(char_index_reg + 1'b1 - lb);
        flush_seg.final_width = off;
        flush_seg.text_done   = 1'b1;
        flush_seg.last_of_run = 1'b1;

        push.count  = {1'b0, brk} + {1'b0, flush};
        push.first  = brk ? brk_seg : flush_seg;
        push.second = flush_seg;

        if (last_char) begin
            char_index_next  = '0;
            line_begin_next  = '0;
            space_index_next = '0;
            line_offset_next = '0;
            word_width_next  = '0;
        end else begin
            char_index_next  = idx_inc;
            line_begin_next  = lb;
            space_index_next = sp;
            line_offset_next = off;
            word_width_next  = ww;
        end
    end

    // Per-text state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            char_index_reg  <= '0;
            line_begin_reg  <= '0;
            space_index_reg <= '0;
            line_offset_reg <= '0;
            word_width_reg  <= '0;
        end else if (take) begin
            char_index_reg  <= char_index_next;
            line_begin_reg  <= line_begin_next;
            space_index_reg <= space_index_next;
            line_offset_reg <= line_offset_next;
            word_width_reg  <= word_width_next;
        end
    end

endmodule

// ===== sv/gtlw_outq.sv =====
module gtlw_outq import gtlw_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_en,
    input  push_t push,
    output logic  room,
    output logic  out_valid,
    input  logic  out_ready,
    output seg_t  out_seg
);

    seg_t               mem_reg [OQ_DEPTH];
    logic [OQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OQ_AW:0]     count_reg, count_next;
    logic [1:0]         n_in;
    logic               pop;

    // Room for two lines, whatever leaves this cycle
    assign room      = count_reg <= (OQ_AW+1)'(OQ_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_seg   = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    assign n_in      = push_en ? push.count : 2'd0;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + OQ_AW'(n_in);
        rd_ptr_next = rd_ptr_reg + OQ_AW'(pop);
        count_next  = count_reg + (OQ_AW+1)'(n_in) - (OQ_AW+1)'(pop);
    end

    // Queue storage
    always_ff @(posedge aclk) begin
        if (n_in != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (n_in == 2'd2) begin
            mem_reg[wr_ptr_reg + 1'b1] <= push.second;
        end
    end

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/greedy_text_line_wrapper.sv =====
// Greedy text line wrapper.
// Input stream: one character per beat. s_tdata carries the character code and
// the glyph advance, s_tlast marks the final character of a text.
// Output stream: one line per beat as start index, length and (on the final
// line of a text) the last line's pixel width; m_tuser flags that final line,
// m_tlast marks the last line caused by a given character.
// Configuration: cfg_addr 0 writes the wrap width, 1 the wrap mode
// (0 newline only, 1 break at any glyph, 2 break at words). Write only
// while no text is in flight; cfg_ready is always high.
// Lines are written into the output queue when the character that ends them
// is accepted. Throughput: one character per cycle while s_tready is high; a
// character that yields two lines gives one output beat for each. Lines wait in a
// four-entry queue; s_tready drops while more than two lines are held.
// Reset: aresetn low clears the line state and the queue, wrap width returns
// to 65535 and the mode to newline only.
// Receiver stall: lines are held in the queue, never dropped, and input
// stalls once the queue cannot take a further two lines.
module greedy_text_line_wrapper import gtlw_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input characters
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] char_code, [15:8] glyph_advance
    input  logic        s_tlast,   // last_char
    // output lines
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] seg_start, [31:16] seg_length,
                                   // [47:32] final_width
    output logic        m_tuser,   // text_done
    output logic        m_tlast,   // last_of_run
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_data
);

    logic [15:0] wrap_width_reg;
    logic [1:0]  wrap_mode_reg;
    logic        take;
    push_t       push;
    seg_t        out_seg;
    logic        room;

    assign cfg_ready = 1'b1;
    assign s_tready  = room;
    assign take      = s_tvalid && room;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_width_reg <= WIDTH_MAX;
            wrap_mode_reg  <= MODE_NEWLINE;
        end else if (cfg_valid) begin
            case (cfg_addr)
                REG_WRAP_WIDTH: wrap_width_reg <= cfg_data;
                REG_WRAP_MODE:  wrap_mode_reg  <= cfg_data[1:0];
                default:        ;
            endcase
        end
    end

    gtlw_core u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .take          (take),
        .char_code     (s_tdata[7:0]),
        .glyph_advance (s_tdata[15:8]),
        .last_char     (s_tlast),
        .wrap_width    (wrap_width_reg),
        .wrap_mode     (wrap_mode_reg),
        .push          (push)
    );

    gtlw_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (take),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_seg   (out_seg)
    );

    // Output beat packing
    assign m_tdata = {out_seg.final_width, out_seg.seg_length, out_seg.seg_start};
    assign m_tuser = out_seg.text_done;
    assign m_tlast = out_seg.last_of_run;

endmodule
